// ===== hdl/spr_pkg.sv =====
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants of the stream pattern replace block: item
// payloads, register indexes, sizes and controller/datapath interfaces.
// ----------------------------------------------------------------------------
package spr_pkg;

   // Sizes
   localparam int BYTE_W      = 8;
   localparam int MAX_PATTERN = 8;
   localparam int MAX_REPLACE = 8;
   localparam int HOLD_DEPTH  = MAX_PATTERN;
   localparam int MAX_OUT     = (MAX_PATTERN > MAX_REPLACE) ? MAX_PATTERN : MAX_REPLACE;
   localparam int POS_W       = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
   localparam int REP_W       = (MAX_REPLACE > 1) ? $clog2(MAX_REPLACE) : 1;
   localparam int CNT_W       = $clog2(MAX_OUT + 1);
   localparam int LEN_W       = 4;
   localparam int STR_W       = 64;
   localparam int CSR_IDX_W   = 8;
   localparam int CSR_DATA_W  = 64;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LEN   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_BYTES = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_LEN   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_BYTES = CSR_IDX_W'(3);

   // Item payloads
   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              end_of_stream;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              run_last;
   } rsp_payload_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;     // take the input item into the match window
      logic analyze;  // compare window against pattern, register the plan
      logic emit;     // push one output byte into the output register
      logic commit;   // keep the unmatched tail as held bytes
   } spr_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic plan_empty; // the plan being registered produces no output byte
      logic emit_last;  // the next emitted byte is the last of this item
      logic out_free;   // the output register can take a byte this cycle
   } spr_status_type;

endpackage

// ===== hdl/stream_pattern_replace.sv =====
// ----------------------------------------------------------------------------
// stream_pattern_replace
// Streaming find-and-replace of a configured byte pattern in a byte stream.
// ----------------------------------------------------------------------------
// Each input item is accepted, then the window of held bytes plus the new
// byte is compared against the pattern, then its output bytes (0 to 8) pass
// one at a time through the output register, and then the unmatched tail is
// kept as held bytes. The emit step stalls while the output register is full
// and not taken. A new item is accepted while the last output byte still
// waits in the output register. Every leftmost, non-overlapping match is
// replaced; bytes that can still start a match are held until decided, and
// end_of_stream flushes them.
// Configuration writes are always accepted, should be issued between streams,
// and any write to a valid index discards the held bytes. No clearing pass.
// ----------------------------------------------------------------------------
module stream_pattern_replace
   import spr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   spr_cmd_type    cmd;
   spr_status_type status;

   assign csr_ready = 1'b1;

   spr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   spr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hdl/spr_ctrl.sv =====
// ----------------------------------------------------------------------------
// spr_ctrl
// Sequencer of the stream pattern replace block: accept, analyze, emit the
// output bytes one per cycle unless stalled, then commit the held bytes.
// ----------------------------------------------------------------------------
module spr_ctrl
   import spr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  spr_status_type status,
   output spr_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_ANALYZE = 4'b0010,
      ST_EMIT    = 4'b0100,
      ST_COMMIT  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_ANALYZE;
            end
         end
         ST_ANALYZE: begin
            cmd.analyze = 1'b1;
            state_in    = status.plan_empty ? ST_COMMIT : ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the output register has room
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.emit_last) begin
                  state_in = ST_COMMIT;
               end
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/spr_datapath.sv =====
// ----------------------------------------------------------------------------
// spr_datapath
// Configuration registers, match window with held bytes, match analysis,
// output byte selection and the output register.
// ----------------------------------------------------------------------------
module spr_datapath
   import spr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  spr_cmd_type           cmd,
   output spr_status_type        status,
   input  req_payload_type       req_data,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_data
);

   localparam int PAT_CAP = (MAX_PATTERN < 8) ? MAX_PATTERN : 8;
   localparam int REP_CAP = (MAX_REPLACE < 8) ? MAX_REPLACE : 8;

   // Clamp the pattern length to 1..PAT_CAP
   function automatic logic [LEN_W-1:0] pat_len_clamp(input logic [LEN_W-1:0] v);
      logic [LEN_W-1:0] l;
      l = v;
      if (l == '0) l = LEN_W'(1);
      if (l > LEN_W'(PAT_CAP)) l = LEN_W'(PAT_CAP);
      return l;
   endfunction

   // Clamp the replacement length to 0..REP_CAP
   function automatic logic [LEN_W-1:0] rep_len_clamp(input logic [LEN_W-1:0] v);
      logic [LEN_W-1:0] r;
      r = v;
      if (r > LEN_W'(REP_CAP)) r = LEN_W'(REP_CAP);
      return r;
   endfunction

   // Configuration
   logic [LEN_W-1:0] pat_len_ff;
   logic [STR_W-1:0] pat_bytes_ff;
   logic [LEN_W-1:0] rep_len_ff;
   logic [STR_W-1:0] rep_bytes_ff;

   // Window and plan
   logic [BYTE_W-1:0] buf_ff [HOLD_DEPTH];
   logic [BYTE_W-1:0] buf_in [HOLD_DEPTH];
   logic [CNT_W-1:0]  held_count_ff;
   logic [CNT_W-1:0]  n_ff;
   logic              eos_ff;
   logic              full_ff;
   logic              full_in;
   logic [CNT_W-1:0]  stop_ff;
   logic [CNT_W-1:0]  stop_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic [CNT_W-1:0]  idx_ff;
   logic [HOLD_DEPTH-1:0] hit;

   // Output register
   logic              rsp_valid_ff;
   rsp_payload_type   rsp_data_ff;
   rsp_payload_type   emit_data;

   // Mark each window position whose tail is a prefix of the pattern
   always_comb begin
      for (int j = 0; j < HOLD_DEPTH; j++) begin
         hit[j] = (CNT_W'(j) < n_ff);
         for (int k = 0; k < HOLD_DEPTH; k++) begin
            if (j + k < HOLD_DEPTH) begin
               if ((CNT_W'(j + k) < n_ff) &&
                   (buf_ff[j + k] != pat_bytes_ff[BYTE_W*k +: BYTE_W])) begin
                  hit[j] = 1'b0;
               end
            end
         end
      end
   end

   // Plan: full match replaces the window, at end of stream emit it all, else emit up to the first hit
   always_comb begin
      full_in = hit[0] && (n_ff == CNT_W'(pat_len_ff));
      stop_in = n_ff;
      for (int j = HOLD_DEPTH - 1; j >= 0; j--) begin
         if (hit[j]) stop_in = CNT_W'(j);
      end
      if (full_in) stop_in = n_ff;
      if (full_in) begin
         cnt_in = CNT_W'(rep_len_ff);
      end else if (eos_ff) begin
         cnt_in = n_ff;
      end else begin
         cnt_in = stop_in;
      end
   end

   // Drop the emitted part of the window, keep the tail at position zero
   always_comb begin
      for (int m = 0; m < HOLD_DEPTH; m++) begin
         buf_in[m] = buf_ff[m];
         for (int s = 1; s <= HOLD_DEPTH; s++) begin
            if ((stop_ff == CNT_W'(s)) && (m + s < HOLD_DEPTH)) begin
               buf_in[m] = buf_ff[m + s];
            end
         end
      end
   end

   // Select the next output byte
   always_comb begin
      if (full_ff) begin
         emit_data.out_byte = rep_bytes_ff[BYTE_W*idx_ff[REP_W-1:0] +: BYTE_W];
      end else begin
         emit_data.out_byte = buf_ff[idx_ff[POS_W-1:0]];
      end
      emit_data.run_last = (idx_ff == cnt_ff - CNT_W'(1));
   end

   assign status.plan_empty = (cnt_in == '0);
   assign status.emit_last  = emit_data.run_last;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff    <= LEN_W'(1);
         pat_bytes_ff  <= '0;
         rep_len_ff    <= '0;
         rep_bytes_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PATTERN_LEN: begin
               pat_len_ff    <= pat_len_clamp(csr_wdata[LEN_W-1:0]);
            end
            CSR_PATTERN_BYTES: begin
               pat_bytes_ff  <= csr_wdata[STR_W-1:0];
            end
            CSR_REPLACE_LEN: begin
               rep_len_ff    <= rep_len_clamp(csr_wdata[LEN_W-1:0]);
            end
            CSR_REPLACE_BYTES: begin
               rep_bytes_ff  <= csr_wdata[STR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Held count: drop on any write to a known register, else keep the tail
   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= '0;
      end else if (csr_valid && (csr_index <= CSR_REPLACE_BYTES)) begin
         held_count_ff <= '0;
      end else if (cmd.commit) begin
         held_count_ff <= eos_ff ? '0 : (n_ff - stop_ff);
      end
   end

   // Window, plan and emit index
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         buf_ff[held_count_ff[POS_W-1:0]] <= req_data.in_byte;
         n_ff   <= held_count_ff + CNT_W'(1);
         eos_ff <= req_data.end_of_stream;
      end
      if (cmd.analyze) begin
         full_ff <= full_in;
         stop_ff <= stop_in;
         cnt_ff  <= cnt_in;
         idx_ff  <= '0;
      end
      if (cmd.emit) begin
         idx_ff <= idx_ff + CNT_W'(1);
      end
      if (cmd.commit) begin
         buf_ff <= buf_in;
      end
   end

   // Output register: load on emit, clear when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= emit_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/spr_checker.sv =====
// ----------------------------------------------------------------------------
// spr_checker
// Port-level checks of the stream pattern replace block, bound to the top.
// ----------------------------------------------------------------------------
module spr_checker
   import spr_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rsp_payload_type       rsp_data,
   input logic                  csr_valid,
   input logic                  csr_ready
);

   // Output item holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("output item changed while stalled");

   // An accepted item blocks input in its analyze state and its emit or commit state
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready)
      else $error("input accepted during item processing");

   // Reset empties the output register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

   // Configuration port never stalls
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write stalled");

endmodule

bind stream_pattern_replace spr_checker u_spr_checker (.*);
